// ===== src/gpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared widths, types and constants of the gas property evaluator.
// ----------------------------------------------------------------------------
package gpe_pkg;

    // field widths
    localparam int T_W   = 19;
    localparam int RS_W  = 26;
    localparam int CP_W  = 28;
    localparam int H_W   = 32;
    localparam int K_W   = 31;
    localparam int MU_W  = 40;

    // polynomial accumulator, signed Q36 with headroom
    localparam int ACC_W = 41;
    typedef logic signed [ACC_W-1:0] acc_t;

    localparam logic [RS_W-1:0] RS_RESET = 26'd19451085;

    // cp coefficients c_k * 1000^k in Q36, index k
    localparam acc_t CP_COEF [5] = '{
        41'sd226683563520,
        41'sd96773515919,
        -41'sd272350404590,
        41'sd387682302396,
        -41'sd168009499893
    };

    // enthalpy coefficients c_k * 1000^k / (k+1) in Q36, index k
    localparam acc_t H_COEF [5] = '{
        41'sd226683563520,
        41'sd48386757959,
        -41'sd90783468197,
        41'sd96920575599,
        -41'sd33601899979
    };

    // reciprocal of 125, floor(2^38 / 125)
    localparam logic [31:0] DIV125_M   = 32'd2199023255;
    // reciprocal of 78125, floor(2^45 / 78125)
    localparam logic [28:0] DIV78125_M = 29'd450359962;

    localparam logic [22:0]    MU_A     = 23'd6186874;
    localparam logic [19:0]    T_OFFSET = 20'd28416;
    localparam logic [K_W-1:0] KAP_BASE = 31'd30043296;

endpackage

// ===== src/gas_property_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_property_evaluator
// Nitrogen cp, enthalpy, conductivity and viscosity from one temperature.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_ready, one temperature per beat.
//   out channel : out_valid / out_ready, four properties per beat.
//   cfg channel : cfg_valid / cfg_ready, gas_constant write, always ready;
//                 write it only while no beat is in flight.
//   One beat per cycle is sustained while the receiver accepts results;
//   the depth is set by the viscosity path: a 22-stage square root followed
//   by a 40-stage restoring divider. The polynomials run through four
//   six-stage Horner steps each.
//   Reset clears all valid bits and loads the nitrogen gas constant.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gas_property_evaluator
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [gpe_pkg::RS_W-1:0] gas_constant,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [gpe_pkg::T_W-1:0]  temperature,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [gpe_pkg::CP_W-1:0] heat_capacity,
    output logic [gpe_pkg::H_W-1:0]  enthalpy,
    output logic [gpe_pkg::K_W-1:0]  conductivity,
    output logic [gpe_pkg::MU_W-1:0] viscosity
);
    import gpe_pkg::*;

    localparam int LAT = 66;

    logic                adv;
    logic [LAT:1]        vld_reg;
    logic [RS_W-1:0]     gas_constant_reg;
    logic [T_W-1:0]      t_reg [1:58];

    acc_t                cp_acc [0:4];
    acc_t                h_acc [0:4];

    logic [29:0]         cp_pp;
    logic [29:0]         h_pp;
    logic [55:0]         cp_prod_reg;
    logic [55:0]         h_prod_reg;
    logic [48:0]         hmt_reg;
    logic [CP_W-1:0]     cp_pipe_reg [27:65];
    logic [H_W-1:0]      h_pipe_reg [28:65];

    logic [28:0]         ka_reg;
    logic [28:0]         ka_s60_reg;
    logic [57:0]         km1_reg;
    logic [12:0]         kq1_reg;
    logic [16:0]         kr1_reg;
    logic [54:0]         km2_reg;
    logic [25:0]         kn2_reg;
    logic [12:0]         kq1_s62_reg;
    logic [12:0]         kq1_s63_reg;
    logic [8:0]          kq2_reg;
    logic [16:0]         kr2_reg;
    logic [53:0]         km3_reg;
    logic [24:0]         kn3_reg;
    logic [12:0]         kq1_s64_reg;
    logic [8:0]          kq2_s64_reg;
    logic [K_W-1:0]      kap_reg;

    logic [12:0]         kq1_next;
    logic [16:0]         kr1_next;
    logic [8:0]          kq2_next;
    logic [16:0]         kr2_next;
    logic [7:0]          kq3_next;
    logic [28:0]         krem1;
    logic [25:0]         krem2;
    logic [24:0]         krem3;
    logic [31:0]         kap_sum;

    logic [23:0]         sq_rem_in [0:21];
    logic [21:0]         sq_root_in [0:21];
    logic [23:0]         sq_rem_reg [0:21];
    logic [21:0]         sq_root_reg [0:21];
    logic [40:0]         ts_reg;
    logic [63:0]         nn_reg;
    logic [19:0]         dv_reg;
    logic [19:0]         div_rem_in [0:39];
    logic [39:0]         div_dq_in [0:39];
    logic [19:0]         div_d_in [0:39];
    logic [19:0]         div_rem_reg [0:39];
    logic [39:0]         div_dq_reg [0:39];
    logic [19:0]         div_d_reg [0:39];

    logic [CP_W-1:0]     heat_capacity_reg;
    logic [H_W-1:0]      enthalpy_reg;
    logic [K_W-1:0]      conductivity_reg;
    logic [MU_W-1:0]     viscosity_reg;

    // pipeline advance and handshakes
    assign adv       = !vld_reg[LAT] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-1:1], in_valid};
        end
    end

    // gas constant register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gas_constant_reg <= RS_RESET;
        end
        else if (cfg_valid)
        begin
            gas_constant_reg <= gas_constant;
        end
    end

    // temperature travels alongside the data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg[1] <= temperature;
            for (int s = 2; s <= 58; s++)
            begin
                t_reg[s] <= t_reg[s-1];
            end
        end
    end

    // Horner chains, stages 2 to 25
    assign cp_acc[0] = CP_COEF[4];
    assign h_acc[0]  = H_COEF[4];

    for (genvar k = 0; k < 4; k++)
    begin : g_horner
        gpe_horner_step u_cp_step
        (
            .clk     (clk),
            .en      (adv),
            .t       (t_reg[1+6*k]),
            .coef    (CP_COEF[3-k]),
            .acc_in  (cp_acc[k]),
            .acc_out (cp_acc[k+1])
        );

        gpe_horner_step u_h_step
        (
            .clk     (clk),
            .en      (adv),
            .t       (t_reg[1+6*k]),
            .coef    (H_COEF[3-k]),
            .acc_in  (h_acc[k]),
            .acc_out (h_acc[k+1])
        );
    end

    // scale by the gas constant; a polynomial at or below zero gives zero
    assign cp_pp = (cp_acc[4] > 0) ? cp_acc[4][39:10] : '0;
    assign h_pp  = (h_acc[4] > 0) ? h_acc[4][39:10] : '0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cp_prod_reg    <= 56'(gas_constant_reg) * 56'(cp_pp);
            h_prod_reg     <= 56'(gas_constant_reg) * 56'(h_pp);
            cp_pipe_reg[27] <= (|cp_prod_reg[55:54]) ? '1 : cp_prod_reg[53:26];
            hmt_reg        <= 49'(h_prod_reg[55:26]) * 49'(t_reg[26]);
            h_pipe_reg[28] <= hmt_reg[48] ? '1 : hmt_reg[47:16];
            for (int s = 28; s <= 65; s++)
            begin
                cp_pipe_reg[s] <= cp_pipe_reg[s-1];
            end
            for (int s = 29; s <= 65; s++)
            begin
                h_pipe_reg[s] <= h_pipe_reg[s-1];
            end
        end
    end

    // conductivity: base + floor(631 * t * 2^17 / 78125), three digits
    always_comb
    begin
        krem1 = ka_s60_reg - 29'(km1_reg[57:45]) * 29'd78125;
        if (krem1[17:0] >= 18'd78125)
        begin
            kq1_next = km1_reg[57:45] + 13'd1;
            kr1_next = 17'(krem1[17:0] - 18'd78125);
        end
        else
        begin
            kq1_next = km1_reg[57:45];
            kr1_next = krem1[16:0];
        end

        krem2 = kn2_reg - 26'(km2_reg[54:45]) * 26'd78125;
        if (krem2[17:0] >= 18'd78125)
        begin
            kq2_next = 9'(km2_reg[54:45] + 10'd1);
            kr2_next = 17'(krem2[17:0] - 18'd78125);
        end
        else
        begin
            kq2_next = km2_reg[53:45];
            kr2_next = krem2[16:0];
        end

        krem3 = kn3_reg - 25'(km3_reg[53:45]) * 25'd78125;
        if (krem3[17:0] >= 18'd78125)
        begin
            kq3_next = 8'(km3_reg[53:45] + 9'd1);
        end
        else
        begin
            kq3_next = km3_reg[52:45];
        end

        kap_sum = 32'(KAP_BASE) + 32'({kq1_s64_reg, kq2_s64_reg, kq3_next});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ka_reg      <= 29'(29'(t_reg[58]) * 29'd631);
            km1_reg     <= 58'(ka_reg) * 58'(DIV78125_M);
            ka_s60_reg  <= ka_reg;
            kq1_reg     <= kq1_next;
            kr1_reg     <= kr1_next;
            km2_reg     <= 55'({kr1_reg, 9'b0}) * 55'(DIV78125_M);
            kn2_reg     <= {kr1_reg, 9'b0};
            kq1_s62_reg <= kq1_reg;
            kq1_s63_reg <= kq1_s62_reg;
            kq2_reg     <= kq2_next;
            kr2_reg     <= kr2_next;
            km3_reg     <= 54'({kr2_reg, 8'b0}) * 54'(DIV78125_M);
            kn3_reg     <= {kr2_reg, 8'b0};
            kq1_s64_reg <= kq1_s63_reg;
            kq2_s64_reg <= kq2_reg;
            kap_reg     <= kap_sum[31] ? '1 : kap_sum[30:0];
        end
    end

    // viscosity square root, two radicand bits per stage, stages 2 to 23
    for (genvar j = 0; j < 22; j++)
    begin : g_sqrt
        logic [43:0] rad;
        logic [25:0] trial;
        logic [25:0] dsub;
        logic [23:0] rem_next;
        logic [21:0] root_next;

        if (j == 0)
        begin : g_first
            assign sq_rem_in[j]  = '0;
            assign sq_root_in[j] = '0;
        end
        else
        begin : g_rest
            assign sq_rem_in[j]  = sq_rem_reg[j-1];
            assign sq_root_in[j] = sq_root_reg[j-1];
        end

        always_comb
        begin
            rad   = {1'b0, t_reg[1+j], 24'b0};
            trial = {sq_rem_in[j], rad[43-2*j -: 2]};
            dsub  = {2'b00, sq_root_in[j], 2'b01};
            if (trial >= dsub)
            begin
                rem_next  = 24'(trial - dsub);
                root_next = {sq_root_in[j][20:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[23:0];
                root_next = {sq_root_in[j][20:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[j]  <= rem_next;
                sq_root_reg[j] <= root_next;
            end
        end
    end

    // numerator and divisor of the viscosity law
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ts_reg <= 41'(t_reg[23]) * 41'(sq_root_reg[21]);
            nn_reg <= 64'(MU_A) * 64'(ts_reg);
            dv_reg <= 20'(t_reg[24]) + T_OFFSET;
        end
    end

    // restoring divider, one quotient bit per stage, stages 26 to 65
    for (genvar i = 0; i < 40; i++)
    begin : g_div
        logic [20:0] trial;
        logic        qbit;
        logic [19:0] rem_next;

        if (i == 0)
        begin : g_first
            assign div_rem_in[i] = {6'b0, nn_reg[63:50]};
            assign div_dq_in[i]  = nn_reg[49:10];
            assign div_d_in[i]   = dv_reg;
        end
        else
        begin : g_rest
            assign div_rem_in[i] = div_rem_reg[i-1];
            assign div_dq_in[i]  = div_dq_reg[i-1];
            assign div_d_in[i]   = div_d_reg[i-1];
        end

        always_comb
        begin
            trial = {div_rem_in[i], div_dq_in[i][39]};
            if (trial >= {1'b0, div_d_in[i]})
            begin
                qbit     = 1'b1;
                rem_next = 20'(trial - {1'b0, div_d_in[i]});
            end
            else
            begin
                qbit     = 1'b0;
                rem_next = trial[19:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_rem_reg[i] <= rem_next;
                div_dq_reg[i]  <= {div_dq_in[i][38:0], qbit};
                div_d_reg[i]   <= div_d_in[i];
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            heat_capacity_reg <= cp_pipe_reg[65];
            enthalpy_reg      <= h_pipe_reg[65];
            conductivity_reg  <= kap_reg;
            viscosity_reg     <= div_dq_reg[39];
        end
    end

    assign heat_capacity = heat_capacity_reg;
    assign enthalpy      = enthalpy_reg;
    assign conductivity  = conductivity_reg;
    assign viscosity     = viscosity_reg;

`ifndef SYNTHESIS
    // a stall freezes every valid bit
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    // square root is exact floor
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[23] |->
            (46'(sq_root_reg[21]) * 46'(sq_root_reg[21]) <= 46'({t_reg[23], 24'b0}))
            && ((46'(sq_root_reg[21]) + 46'd1) * (46'(sq_root_reg[21]) + 46'd1)
                > 46'({t_reg[23], 24'b0})))
        else $error("square root out of range");

    // divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[65] |-> (div_rem_reg[39] < div_d_reg[39]))
        else $error("divider remainder not reduced");

    // conductivity first digit remainder is reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[61] |-> (kr1_reg < 17'd78125))
        else $error("conductivity remainder not reduced");
`endif

endmodule

// ===== src/gpe_horner_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_horner_step
// One Horner step, acc_out = floor(acc_in * t / 256000) + coef, six stages.
// ----------------------------------------------------------------------------
module gpe_horner_step
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [gpe_pkg::T_W-1:0] t,
    input  gpe_pkg::acc_t           coef,
    input  gpe_pkg::acc_t           acc_in,
    output gpe_pkg::acc_t           acc_out
);
    import gpe_pkg::*;

    localparam logic [54:0]        U_OFFSET = 55'd125 << 48;
    localparam logic signed [50:0] Q_OFFSET = 51'sd1 <<< 48;

    logic signed [60:0] prod_reg;
    logic [54:0]        u_reg;
    logic [62:0]        mh_reg;
    logic [30:0]        uh_reg;
    logic [23:0]        ul_reg;
    logic [24:0]        q1_reg;
    logic [6:0]         r1_reg;
    logic [23:0]        ul2_reg;
    logic [62:0]        m2_reg;
    logic [30:0]        n2_reg;
    logic [24:0]        q1b_reg;
    acc_t               acc_reg;

    logic [24:0]        q1_next;
    logic [6:0]         r1_next;
    logic [30:0]        rem1;
    logic [30:0]        n2_next;
    logic [24:0]        qe2;
    logic [30:0]        rem2;
    logic [23:0]        q2;
    logic signed [50:0] sum;
    acc_t               acc_next;

    // first chunk: correct the reciprocal estimate of uh / 125
    always_comb
    begin
        rem1 = uh_reg - 31'(mh_reg[62:38]) * 31'd125;
        if (rem1[7:0] >= 8'd125)
        begin
            q1_next = mh_reg[62:38] + 25'd1;
            r1_next = 7'(rem1[7:0] - 8'd125);
        end
        else
        begin
            q1_next = mh_reg[62:38];
            r1_next = rem1[6:0];
        end
    end

    assign n2_next = {r1_reg, ul2_reg};

    // second chunk, then add the coefficient
    always_comb
    begin
        qe2  = m2_reg[62:38];
        rem2 = n2_reg - 31'(qe2) * 31'd125;
        if (rem2[7:0] >= 8'd125)
        begin
            q2 = 24'(qe2 + 25'd1);
        end
        else
        begin
            q2 = qe2[23:0];
        end
        sum      = $signed({2'b00, q1b_reg, q2}) - Q_OFFSET + 51'(coef);
        acc_next = sum[ACC_W-1:0];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= acc_in * $signed({1'b0, t});
            u_reg    <= 55'($signed(prod_reg[60:11])) + U_OFFSET;
            mh_reg   <= 63'(u_reg[54:24]) * 63'(DIV125_M);
            uh_reg   <= u_reg[54:24];
            ul_reg   <= u_reg[23:0];
            q1_reg   <= q1_next;
            r1_reg   <= r1_next;
            ul2_reg  <= ul_reg;
            m2_reg   <= 63'(n2_next) * 63'(DIV125_M);
            n2_reg   <= n2_next;
            q1b_reg  <= q1_reg;
            acc_reg  <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule
